// ===== src/lpr_pkg.sv =====
// ----------------------------------------------------------------------------
// LRU page replacement package
// Shared constants and control types for the frame table datapath.
// ----------------------------------------------------------------------------
package lpr_pkg;

  // Default build sizes.
  localparam int unsigned NumFramesDef = 16;
  localparam int unsigned PageBitsDef  = 16;

  // Fixed field widths.
  localparam int unsigned CfgW      = 5;
  localparam int unsigned StampW    = 32;
  localparam int unsigned TotalW    = 32;
  localparam int unsigned FrameIdxW = 4;

  // Reset value of the frames_in_use register.
  localparam logic [CfgW-1:0] FramesReset = 5'd16;

  // All-ones value: saturation limit of the clock and counters.
  localparam logic [StampW-1:0] SatStamp = '1;

  // Per-sample control from the sequencer to the search unit.
  typedef struct packed {
    logic clear;
    logic sample;
    logic entry_valid;
  } scan_ctl_t;

  // Search results that are plain flags.
  typedef struct packed {
    logic found;
    logic have_empty;
  } scan_flags_t;

endpackage

// ===== src/lpr_frame_mem.sv =====
// ----------------------------------------------------------------------------
// LRU frame memory
// One-port-write, one-port-read synchronous RAM holding page and use stamp
// of every frame. Read data is registered.
// ----------------------------------------------------------------------------
module lpr_frame_mem #(
  parameter int unsigned Depth = lpr_pkg::NumFramesDef,
  parameter int unsigned Width = lpr_pkg::PageBitsDef + lpr_pkg::StampW,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== src/lpr_scan.sv =====
// ----------------------------------------------------------------------------
// LRU search unit
// Takes one frame entry per cycle while sample is high, and keeps the first
// matching frame, the first empty and the oldest valid frame seen so far.
// ----------------------------------------------------------------------------
module lpr_scan #(
  parameter int unsigned NumFrames = lpr_pkg::NumFramesDef,
  parameter int unsigned PageBits  = lpr_pkg::PageBitsDef,
  localparam int unsigned IdxW = (NumFrames > 1) ? $clog2(NumFrames) : 1
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  lpr_pkg::scan_ctl_t        ctl_i,
  input  logic [IdxW-1:0]           idx_i,
  input  logic [PageBits-1:0]       key_i,
  input  logic [PageBits-1:0]       page_i,
  input  logic [lpr_pkg::StampW-1:0] stamp_i,
  output lpr_pkg::scan_flags_t      flags_o,
  output logic [IdxW-1:0]           hit_at_o,
  output logic [IdxW-1:0]           empty_at_o,
  output logic [IdxW-1:0]           lru_at_o,
  output logic [PageBits-1:0]       lru_page_o
);

  lpr_pkg::scan_flags_t        flags_q;
  logic [IdxW-1:0]             hit_at_q, empty_at_q, lru_at_q;
  logic [PageBits-1:0]         lru_page_q;
  logic [lpr_pkg::StampW-1:0]  lru_stamp_q;

  // Running search over the entries of one pass.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flags_q     <= '0;
      hit_at_q    <= '0;
      empty_at_q  <= '0;
      lru_at_q    <= '0;
      lru_page_q  <= '0;
      lru_stamp_q <= lpr_pkg::SatStamp;
    end else if (ctl_i.clear) begin
      flags_q     <= '0;
      lru_at_q    <= '0;
      lru_stamp_q <= lpr_pkg::SatStamp;
    end else if (ctl_i.sample) begin
      if (ctl_i.entry_valid) begin
        if (!flags_q.found && (page_i == key_i)) begin
          flags_q.found <= 1'b1;
          hit_at_q      <= idx_i;
        end
        // Strict compare keeps the lowest index on equal stamps.
        if ((idx_i == '0) || (stamp_i < lru_stamp_q)) begin
          lru_stamp_q <= stamp_i;
          lru_at_q    <= idx_i;
          lru_page_q  <= page_i;
        end
      end else if (!flags_q.have_empty) begin
        flags_q.have_empty <= 1'b1;
        empty_at_q         <= idx_i;
      end
    end
  end

  assign flags_o    = flags_q;
  assign hit_at_o   = hit_at_q;
  assign empty_at_o = empty_at_q;
  assign lru_at_o   = lru_at_q;
  assign lru_page_o = lru_page_q;

endmodule

// ===== src/lru_page_replacement.sv =====
// ----------------------------------------------------------------------------
// LRU page replacement
// Fully associative least-recently-used frame table with fault and hit totals.
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy is low. The block reads the
// active frames from its frame memory one per cycle, decides hit, fill or
// eviction, and writes the chosen frame back while busy; the result appears
// on done_o for exactly one cycle right after, and a new item may be started
// in that same cycle. The receiver cannot stall results. The user must write
// frames_in_use only while the block is idle; the block itself does not
// enforce it. 0 acts as 1 and values above the built frame count act as that
// count. Frames outside the active range keep their contents. Frame valid
// bits are cleared by reset, so no memory clearing pass is needed.
module lru_page_replacement #(
  parameter int unsigned NUM_FRAMES = lpr_pkg::NumFramesDef,
  parameter int unsigned PAGE_BITS  = lpr_pkg::PageBitsDef
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [lpr_pkg::CfgW-1:0]    cfg_wdata_i,
  input  logic                        start,
  output logic                        busy,
  input  logic [PAGE_BITS-1:0]        page_number_i,
  output logic                        done_o,
  output logic                        hit_o,
  output logic [lpr_pkg::FrameIdxW-1:0] frame_index_o,
  output logic                        evicted_valid_o,
  output logic [PAGE_BITS-1:0]        evicted_page_o,
  output logic [lpr_pkg::TotalW-1:0]  fault_total_o,
  output logic [lpr_pkg::TotalW-1:0]  hit_total_o
);

  localparam int unsigned IdxW   = (NUM_FRAMES > 1) ? $clog2(NUM_FRAMES) : 1;
  localparam int unsigned EntryW = PAGE_BITS + lpr_pkg::StampW;

  typedef enum logic [1:0] {
    StIdle,
    StScan,
    StDrain,
    StDecide
  } state_e;

  state_e                        state_q;
  logic [lpr_pkg::CfgW-1:0]      frames_in_use_q;
  logic [IdxW-1:0]               last_q, cnt_q, samp_idx_q;
  logic                          samp_vld_q;
  logic [PAGE_BITS-1:0]          page_q;
  logic [NUM_FRAMES-1:0]         valid_q;
  logic [lpr_pkg::StampW-1:0]    use_clock_q;
  logic [lpr_pkg::TotalW-1:0]    fault_cnt_q, hit_cnt_q;
  logic                          done_q, hit_q, ev_vld_q;
  logic [IdxW-1:0]               target_q;
  logic [PAGE_BITS-1:0]          ev_page_q;

  logic [IdxW-1:0]               last_d;
  logic [lpr_pkg::StampW-1:0]    use_clock_d;
  logic [IdxW-1:0]               target_d;
  logic                          mem_we, mem_re;
  logic [EntryW-1:0]             mem_rdata;
  logic [PAGE_BITS-1:0]          rd_page;
  logic [lpr_pkg::StampW-1:0]    rd_stamp;
  lpr_pkg::scan_ctl_t            scan_ctl;
  lpr_pkg::scan_flags_t          scan_flags;
  logic [IdxW-1:0]               hit_at, empty_at, lru_at;
  logic [PAGE_BITS-1:0]          lru_page;
  logic                          accept;

  assign accept = start && !busy;
  assign busy   = (state_q != StIdle);

  // Index of the last active frame from the register value.
  always_comb begin
    if (frames_in_use_q == '0) begin
      last_d = '0;
    end else if (32'(frames_in_use_q) > 32'(NUM_FRAMES)) begin
      last_d = IdxW'(NUM_FRAMES - 1);
    end else begin
      last_d = IdxW'(32'(frames_in_use_q) - 32'd1);
    end
  end

  // Configuration register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frames_in_use_q <= lpr_pkg::FramesReset;
    end else if (cfg_we_i) begin
      frames_in_use_q <= cfg_wdata_i;
    end
  end

  // Frame memory and its read pipeline.
  assign mem_re = (state_q == StScan);
  assign mem_we = (state_q == StDecide);
  assign {rd_page, rd_stamp} = mem_rdata;

  lpr_frame_mem #(
    .Depth (NUM_FRAMES),
    .Width (EntryW)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (target_d),
    .wdata_i ({page_q, use_clock_d}),
    .re_i    (mem_re),
    .raddr_i (cnt_q),
    .rdata_o (mem_rdata)
  );

  // Search unit sees each entry in the cycle after its read.
  assign scan_ctl.clear       = accept;
  assign scan_ctl.sample      = samp_vld_q;
  assign scan_ctl.entry_valid = valid_q[samp_idx_q];

  lpr_scan #(
    .NumFrames (NUM_FRAMES),
    .PageBits  (PAGE_BITS)
  ) u_scan (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctl_i      (scan_ctl),
    .idx_i      (samp_idx_q),
    .key_i      (page_q),
    .page_i     (rd_page),
    .stamp_i    (rd_stamp),
    .flags_o    (scan_flags),
    .hit_at_o   (hit_at),
    .empty_at_o (empty_at),
    .lru_at_o   (lru_at),
    .lru_page_o (lru_page)
  );

  // Decision: hit frame, first empty frame, or oldest frame.
  always_comb begin
    use_clock_d = (use_clock_q == lpr_pkg::SatStamp) ? use_clock_q
                                                    : use_clock_q + 1'b1;
    if (scan_flags.found) begin
      target_d = hit_at;
    end else if (scan_flags.have_empty) begin
      target_d = empty_at;
    end else begin
      target_d = lru_at;
    end
  end

  // Sequencer, state and result registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      last_q      <= '0;
      cnt_q       <= '0;
      samp_idx_q  <= '0;
      samp_vld_q  <= 1'b0;
      page_q      <= '0;
      valid_q     <= '0;
      use_clock_q <= '0;
      fault_cnt_q <= '0;
      hit_cnt_q   <= '0;
      done_q      <= 1'b0;
      hit_q       <= 1'b0;
      ev_vld_q    <= 1'b0;
      target_q    <= '0;
      ev_page_q   <= '0;
    end else begin
      done_q     <= 1'b0;
      samp_vld_q <= 1'b0;
      case (state_q)
        StIdle: begin
          if (accept) begin
            page_q  <= page_number_i;
            last_q  <= last_d;
            cnt_q   <= '0;
            state_q <= StScan;
          end
        end
        StScan: begin
          samp_vld_q <= 1'b1;
          samp_idx_q <= cnt_q;
          cnt_q      <= cnt_q + 1'b1;
          if (cnt_q == last_q) begin
            state_q <= StDrain;
          end
        end
        StDrain: begin
          state_q <= StDecide;
        end
        StDecide: begin
          use_clock_q <= use_clock_d;
          target_q    <= target_d;
          hit_q       <= scan_flags.found;
          done_q      <= 1'b1;
          if (scan_flags.found) begin
            ev_vld_q  <= 1'b0;
            ev_page_q <= '0;
            if (hit_cnt_q != lpr_pkg::SatStamp) begin
              hit_cnt_q <= hit_cnt_q + 1'b1;
            end
          end else begin
            valid_q[target_d] <= 1'b1;
            ev_vld_q  <= !scan_flags.have_empty;
            ev_page_q <= scan_flags.have_empty ? '0 : lru_page;
            if (fault_cnt_q != lpr_pkg::SatStamp) begin
              fault_cnt_q <= fault_cnt_q + 1'b1;
            end
          end
          state_q <= StIdle;
        end
        default: begin
          state_q <= StIdle;
        end
      endcase
    end
  end

  assign done_o          = done_q;
  assign hit_o           = hit_q;
  assign frame_index_o   = lpr_pkg::FrameIdxW'(32'(target_q));
  assign evicted_valid_o = ev_vld_q;
  assign evicted_page_o  = ev_page_q;
  assign fault_total_o   = fault_cnt_q;
  assign hit_total_o     = hit_cnt_q;

`ifndef SYNTH
  // A result follows only the decision step.
  a_done_after_decide: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> $past(state_q == StDecide))
    else $error("result strobe without a decision step");

  // A hit never reports an eviction.
  a_hit_no_evict: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_q && hit_q) |-> (!ev_vld_q && (ev_page_q == '0)))
    else $error("eviction reported on a hit");

  // An accepted item keeps the block busy in the next cycle.
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> busy)
    else $error("item accepted but block not busy");

  // The written frame is valid once the result is shown.
  a_target_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> valid_q[target_q])
    else $error("result frame is not valid");
`endif

endmodule

// ===== verif/tb_lru_page_replacement.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LRU page replacement testbench
// Drives directed page references and random bursts through the frame table
// and checks every result (hit, frame, evicted page, totals) against an
// in-bench LRU table model, across several settings of the frame count.
// ----------------------------------------------------------------------------

// Expected or observed outcome of one page reference.
typedef struct packed {
  logic                           hit;
  logic [lpr_pkg::FrameIdxW-1:0]  frame_index;
  logic                           evicted_valid;
  logic [lpr_pkg::PageBitsDef-1:0] evicted_page;
  logic [lpr_pkg::TotalW-1:0]     fault_total;
  logic [lpr_pkg::TotalW-1:0]     hit_total;
} access_result_t;

// Scoreboard: keeps its own frame table and the queue of outcomes still due.
class lru_scoreboard;
  logic [lpr_pkg::PageBitsDef-1:0] frame_page [lpr_pkg::NumFramesDef];
  bit                              frame_valid[lpr_pkg::NumFramesDef];
  logic [lpr_pkg::StampW-1:0]      use_stamp  [lpr_pkg::NumFramesDef];
  logic [lpr_pkg::StampW-1:0]      use_clock;
  logic [lpr_pkg::TotalW-1:0]      fault_count;
  logic [lpr_pkg::TotalW-1:0]      hit_count;
  logic [lpr_pkg::CfgW-1:0]        frames_cfg;
  access_result_t                  outcomes_due[$];
  int                              errors;

  function new();
    for (int i = 0; i < lpr_pkg::NumFramesDef; i++) begin
      frame_page[i]  = '0;
      frame_valid[i] = 1'b0;
      use_stamp[i]   = '0;
    end
    use_clock   = '0;
    fault_count = '0;
    hit_count   = '0;
    frames_cfg  = lpr_pkg::FramesReset;
    errors      = 0;
  endfunction

  function void set_frames(logic [lpr_pkg::CfgW-1:0] value);
    frames_cfg = value;
  endfunction

  function int pending();
    return outcomes_due.size();
  endfunction

  // Counters and the use clock stop at all ones.
  function logic [31:0] bump(logic [31:0] value);
    return (value == lpr_pkg::SatStamp) ? value : value + 1;
  endfunction

  // Runs one reference through the LRU table and queues the outcome.
  function void note_access(logic [lpr_pkg::PageBitsDef-1:0] page);
    int unsigned                n;
    bit                         found;
    bit                         have_empty;
    int unsigned                hit_at;
    int unsigned                empty_at;
    int unsigned                lru_at;
    int unsigned                target;
    logic [lpr_pkg::StampW-1:0] lru_stamp;
    access_result_t             r;
    n          = frames_cfg;
    found      = 1'b0;
    have_empty = 1'b0;
    hit_at     = 0;
    empty_at   = 0;
    lru_at     = 0;
    lru_stamp  = lpr_pkg::SatStamp;
    if (n == 0) n = 1;
    if (n > lpr_pkg::NumFramesDef) n = lpr_pkg::NumFramesDef;

    // Search the active frames for the page, the first hole and the oldest.
    for (int unsigned i = 0; i < n; i++) begin
      if (frame_valid[i]) begin
        if (!found && frame_page[i] == page) begin
          found  = 1'b1;
          hit_at = i;
        end
        if (i == 0 || use_stamp[i] < lru_stamp) begin
          lru_stamp = use_stamp[i];
          lru_at    = i;
        end
      end else if (!have_empty) begin
        have_empty = 1'b1;
        empty_at   = i;
      end
    end

    use_clock       = bump(use_clock);
    r.evicted_valid = 1'b0;
    r.evicted_page  = '0;
    if (found) begin
      r.hit     = 1'b1;
      target    = hit_at;
      hit_count = bump(hit_count);
    end else begin
      r.hit       = 1'b0;
      fault_count = bump(fault_count);
      if (have_empty) begin
        target = empty_at;
      end else begin
        target          = lru_at;
        r.evicted_valid = 1'b1;
        r.evicted_page  = frame_page[target];
      end
      frame_page[target]  = page;
      frame_valid[target] = 1'b1;
    end
    use_stamp[target] = use_clock;

    r.frame_index = target[lpr_pkg::FrameIdxW-1:0];
    r.fault_total = fault_count;
    r.hit_total   = hit_count;
    outcomes_due.push_back(r);
  endfunction

  // Compares one observed outcome with the oldest one due.
  function void check_result(access_result_t got);
    access_result_t exp_r;
    if (outcomes_due.size() == 0) begin
      $error("result with no item outstanding: frame_index %0d", got.frame_index);
      errors++;
      return;
    end
    exp_r = outcomes_due.pop_front();
    if (got.hit !== exp_r.hit) begin
      $error("hit: expected %0d, actual %0d", exp_r.hit, got.hit);
      errors++;
    end
    if (got.frame_index !== exp_r.frame_index) begin
      $error("frame_index: expected %0d, actual %0d", exp_r.frame_index, got.frame_index);
      errors++;
    end
    if (got.evicted_valid !== exp_r.evicted_valid) begin
      $error("evicted_valid: expected %0d, actual %0d", exp_r.evicted_valid,
             got.evicted_valid);
      errors++;
    end
    if (got.evicted_page !== exp_r.evicted_page) begin
      $error("evicted_page: expected %h, actual %h", exp_r.evicted_page, got.evicted_page);
      errors++;
    end
    if (got.fault_total !== exp_r.fault_total) begin
      $error("fault_total: expected %0d, actual %0d", exp_r.fault_total, got.fault_total);
      errors++;
    end
    if (got.hit_total !== exp_r.hit_total) begin
      $error("hit_total: expected %0d, actual %0d", exp_r.hit_total, got.hit_total);
      errors++;
    end
  endfunction
endclass

module tb_lru_page_replacement;

  localparam int PageW      = lpr_pkg::PageBitsDef;
  localparam int IdleLimit  = 500;
  localparam int Segments   = 10;
  localparam int SegItems   = 130;
  localparam int PoolMax    = 24;

  logic                          clk_i           = 1'b0;
  logic                          rst_ni          = 1'b0;
  logic                          cfg_we_i        = 1'b0;
  logic [lpr_pkg::CfgW-1:0]      cfg_wdata_i     = '0;
  logic                          start           = 1'b0;
  logic [PageW-1:0]              page_number_i   = '0;
  logic                          busy;
  logic                          done_o;
  logic                          hit_o;
  logic [lpr_pkg::FrameIdxW-1:0] frame_index_o;
  logic                          evicted_valid_o;
  logic [PageW-1:0]              evicted_page_o;
  logic [lpr_pkg::TotalW-1:0]    fault_total_o;
  logic [lpr_pkg::TotalW-1:0]    hit_total_o;

  lru_scoreboard         sb;
  logic [PageW-1:0]      page_pool[PoolMax];
  int                    idle_cycles = 0;

  lru_page_replacement #(
    .NUM_FRAMES(lpr_pkg::NumFramesDef),
    .PAGE_BITS (lpr_pkg::PageBitsDef)
  ) uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .start          (start),
    .busy           (busy),
    .page_number_i  (page_number_i),
    .done_o         (done_o),
    .hit_o          (hit_o),
    .frame_index_o  (frame_index_o),
    .evicted_valid_o(evicted_valid_o),
    .evicted_page_o (evicted_page_o),
    .fault_total_o  (fault_total_o),
    .hit_total_o    (hit_total_o)
  );

  always #5 clk_i = ~clk_i;

  // Every strobed result is checked at the edge that ends its cycle.
  always @(posedge clk_i) begin
    access_result_t got;
    if (rst_ni && done_o) begin
      got.hit           = hit_o;
      got.frame_index   = frame_index_o;
      got.evicted_valid = evicted_valid_o;
      got.evicted_page  = evicted_page_o;
      got.fault_total   = fault_total_o;
      got.hit_total     = hit_total_o;
      sb.check_result(got);
    end
  end

  // Watchdog: ends the run after too long without any item or result moving.
  always @(posedge clk_i) begin
    if (!rst_ni || (start && !busy) || done_o) begin
      idle_cycles <= 0;
    end else if (idle_cycles + 1 >= IdleLimit) begin
      $display("simulation failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Presents one page and holds it until the block takes it.
  task automatic drive_access(input logic [PageW-1:0] page);
    start         <= 1'b1;
    page_number_i <= page;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    sb.note_access(page);
  endtask

  // Stops sending and waits until every outstanding result has arrived.
  task automatic drain;
    start <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  // Frame count is changed only with the block idle.
  task automatic write_frames(input logic [lpr_pkg::CfgW-1:0] value);
    drain();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    sb.set_frames(value);
    cfg_we_i    <= 1'b0;
  endtask

  initial begin
    logic [lpr_pkg::CfgW-1:0] cfg_value;
    int              active;
    int              pool_size;
    int              sent;
    int              burst_len;
    int              gap;
    logic [PageW-1:0] page;
    sb = new();
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset frame count: fills, a hit, both page extremes.
    drive_access(16'h0000);
    drive_access(16'hFFFF);
    drive_access(16'h0000);
    drive_access(16'hA5A5);
    drive_access(16'h5A5A);

    // A count of zero acts as one frame; frames above it are not searched.
    write_frames(5'd0);
    drive_access(16'h1234);
    drive_access(16'h1234);
    drive_access(16'hFFFF);

    // Counts above the built size act as the full table.
    write_frames(5'd31);
    drive_access(16'hFFFF);
    drive_access(16'h0001);
    write_frames(5'd17);
    drive_access(16'h8000);
    drive_access(16'h0000);

    // Two frames: evictions in LRU order.
    write_frames(5'd2);
    drive_access(16'h0101);
    drive_access(16'h0202);
    drive_access(16'h0101);
    drive_access(16'h0303);

    // Raising the count again brings back the frames left untouched.
    write_frames(5'd16);
    drive_access(16'hA5A5);
    drive_access(16'h5A5A);

    // Random segments: a working set up to four pages larger than the frame count,
    // with some fully random pages mixed in.
    for (int seg = 0; seg < Segments; seg++) begin
      case (seg)
        0: cfg_value = 5'd1;
        1: cfg_value = 5'd16;
        2: cfg_value = 5'd0;
        3: cfg_value = 5'd31;
        4: cfg_value = 5'd4;
        default: cfg_value = lpr_pkg::CfgW'($urandom_range(0, 31));
      endcase
      write_frames(cfg_value);
      active = (cfg_value == 0) ? 1 :
               (cfg_value > lpr_pkg::NumFramesDef) ? lpr_pkg::NumFramesDef : cfg_value;
      pool_size = active + $urandom_range(0, 4);
      if (pool_size > PoolMax) pool_size = PoolMax;
      for (int k = 0; k < pool_size; k++) begin
        page_pool[k] = PageW'($urandom);
      end

      sent = 0;
      while (sent < SegItems) begin
        burst_len = $urandom_range(1, 20);
        for (int b = 0; b < burst_len && sent < SegItems; b++) begin
          if ($urandom_range(0, 99) < 85) begin
            page = page_pool[$urandom_range(0, pool_size - 1)];
          end else begin
            page = PageW'($urandom);
          end
          drive_access(page);
          sent++;
        end
        if (sent < SegItems) begin
          // Between bursts: sometimes wait for all results, else a random gap or none.
          if ($urandom_range(0, 15) == 0) begin
            drain();
          end else begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 25);
            if (gap != 0) begin
              start <= 1'b0;
              repeat (gap) @(posedge clk_i);
            end
          end
        end
      end
    end

    // Let everything settle, then give the verdict.
    drain();
    repeat (40) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ===== lru_page_replacement.f =====
src/lpr_pkg.sv
src/lpr_frame_mem.sv
src/lpr_scan.sv
src/lru_page_replacement.sv
verif/tb_lru_page_replacement.sv
